// ----- rtl/positional_list_engine_core_defines.svh -----
// assertion macros for the positional list engine
// used by the top level, which must declare clk and rst
`ifndef POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ple assertion failed");
`define PLE_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
`else
`define PLE_ASSERT(lbl, prop)
`define PLE_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ----- rtl/ple_pkg.sv -----
// shared types and constants of the positional list engine
// no dependencies
package ple_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 5;
  localparam int CNT_W   = 5;

  typedef enum logic [2:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_TAIL = 3'd1,
    ACT_INS_AT   = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4,
    ACT_REM_AT   = 3'd5,
    ACT_READ_AT  = 3'd6,
    ACT_CONTAINS = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_HOLD  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_LEFT  = 2'd2,
    MODE_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       start;
    logic       drain;
    logic       sel;
    logic       chk;
  } cell_ctl_t;

endpackage

// ----- rtl/ple_if.sv -----
// request and response channels of the positional list engine
// depends on ple_pkg
interface ple_req_if;
  logic                              valid;
  logic                              ready;
  ple_pkg::action_t                  action;
  logic signed [ple_pkg::DATA_W-1:0] value;
  logic [ple_pkg::POS_W-1:0]         position;

  modport source(output valid, action, value, position, input ready);
  modport sink(input valid, action, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic                              valid;
  logic                              ready;
  ple_pkg::status_t                  status;
  logic signed [ple_pkg::DATA_W-1:0] value_out;
  logic                              found;
  logic [ple_pkg::CNT_W-1:0]         count_out;

  modport source(output valid, status, value_out, found, count_out, input ready);
  modport sink(input valid, status, value_out, found, count_out, output ready);
endinterface

// ----- rtl/ple_cell.sv -----
// one list cell: holds an entry, shifts with its neighbors, and feeds the
// result chain that collects a picked value and a match flag toward cell 0
// depends on ple_pkg
module ple_cell (
  input  logic                              clk,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  input  logic signed [ple_pkg::DATA_W-1:0] left_data,
  input  logic signed [ple_pkg::DATA_W-1:0] right_data,
  input  logic signed [ple_pkg::DATA_W-1:0] pick_in,
  input  logic                              found_in,
  output logic signed [ple_pkg::DATA_W-1:0] data,
  output logic signed [ple_pkg::DATA_W-1:0] pick,
  output logic                              found
);

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      ple_pkg::MODE_HOLD:  data <= data;
      ple_pkg::MODE_LOAD:  data <= value;
      ple_pkg::MODE_LEFT:  data <= left_data;
      ple_pkg::MODE_RIGHT: data <= right_data;
    endcase
  end

  // pick and found sample the old entry, before any shift lands
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      pick  <= ctl.sel ? data : '0;
      found <= ctl.chk && (data == value);
    end else if (ctl.drain) begin
      pick  <= pick | pick_in;
      found <= found | found_in;
    end
  end

endmodule

// ----- rtl/positional_list_engine_core.sv -----
// top level of the positional list engine: control, count and cell chain
// depends on ple_pkg, ple_if, ple_cell and the defines header
`include "positional_list_engine_core_defines.svh"

// Keeps an ordered list of up to DEPTH signed 32-bit entries in a row of
// cells that shift toward the tail on insert and toward the head on remove,
// all in the cycle the request is accepted. Inserts and every rejected
// request (bad position, empty, full) register their result on acceptance.
// Remove, read and contains drain first: the picked entry and the match
// flags travel through the cell chain toward cell 0 one cell per cycle,
// DEPTH-1 steps, before the result is registered. A new request is
// taken only while no chain drain is running and the response register is
// empty or being read in the same cycle, so a waiting result holds off input.
// count_out is the entry count taken modulo 32.
module positional_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  ple_req_if.sink     req,
  ple_rsp_if.source   rsp
);

  localparam int DW = ple_pkg::DATA_W;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int KW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [KW-1:0]    cnt;
  logic [XW-1:0]    cnt_x, ep, cn_x;
  ple_pkg::status_t st;
  logic             do_ins, do_rem, do_read, do_chk, need_drain;
  logic             accept, out_free, out_load, drain_load;

  logic signed [DW-1:0] data [DEPTH];
  logic signed [DW-1:0] pick [DEPTH];
  logic                 found_c [DEPTH];

  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && out_free;
  assign accept     = req.valid && req.ready;
  assign cnt_x      = XW'(count);

  always_comb begin
    unique case (req.action)
      ple_pkg::ACT_INS_HEAD, ple_pkg::ACT_REM_HEAD: ep = '0;
      ple_pkg::ACT_INS_TAIL:                        ep = cnt_x;
      ple_pkg::ACT_REM_TAIL:                        ep = cnt_x - XW'(1);
      default:                                      ep = XW'(req.position);
    endcase
  end

  always_comb begin
    st      = ple_pkg::ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_read = 1'b0;
    do_chk  = 1'b0;
    unique case (req.action)
      ple_pkg::ACT_INS_HEAD, ple_pkg::ACT_INS_TAIL, ple_pkg::ACT_INS_AT: begin
        if (ep > cnt_x) st = ple_pkg::ST_BADPOS;
        else if (count == CW'(DEPTH)) st = ple_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      ple_pkg::ACT_REM_HEAD, ple_pkg::ACT_REM_TAIL: begin
        if (count == '0) st = ple_pkg::ST_EMPTY;
        else do_rem = 1'b1;
      end
      ple_pkg::ACT_REM_AT: begin
        if (ep >= cnt_x) st = ple_pkg::ST_BADPOS;
        else do_rem = 1'b1;
      end
      ple_pkg::ACT_READ_AT: begin
        if (ep >= cnt_x) st = ple_pkg::ST_BADPOS;
        else do_read = 1'b1;
      end
      ple_pkg::ACT_CONTAINS: do_chk = 1'b1;
    endcase
  end

  assign need_drain = do_rem || do_read || do_chk;

  always_comb begin
    count_next = count;
    if (accept && do_ins) count_next = count + CW'(1);
    else if (accept && do_rem) count_next = count - CW'(1);
  end
  assign cn_x = XW'(count_next);

  assign drain_load = (state == S_DRAIN) && (cnt == KW'(DEPTH - 1)) && out_free;
  assign out_load   = (accept && !need_drain) || drain_load;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && need_drain) state_next = S_DRAIN;
      S_DRAIN: if (drain_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (accept) cnt <= '0;
      else if (state == S_DRAIN && cnt != KW'(DEPTH - 1)) cnt <= cnt + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (out_load) rsp.valid <= 1'b1;
    else if (rsp.ready) rsp.valid <= 1'b0;
  end

  // count has already moved when a drained result is loaded
  always_ff @(posedge clk) begin
    if (accept && !need_drain) begin
      rsp.status    <= st;
      rsp.value_out <= '0;
      rsp.found     <= 1'b0;
      rsp.count_out <= cn_x[ple_pkg::CNT_W-1:0];
    end else if (drain_load) begin
      rsp.status    <= ple_pkg::ST_OK;
      rsp.value_out <= pick[0];
      rsp.found     <= found_c[0];
      rsp.count_out <= cn_x[ple_pkg::CNT_W-1:0];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [XW-1:0] IX = XW'(i);
    ple_pkg::cell_ctl_t   ctl;
    logic signed [DW-1:0] left_d, right_d, pick_in;
    logic                 found_in;

    always_comb begin
      ctl.mode = ple_pkg::MODE_HOLD;
      if (accept && do_ins) begin
        if (IX == ep) ctl.mode = ple_pkg::MODE_LOAD;
        else if (IX > ep && IX <= cnt_x) ctl.mode = ple_pkg::MODE_LEFT;
      end else if (accept && do_rem) begin
        if (IX >= ep && IX + XW'(1) < cnt_x) ctl.mode = ple_pkg::MODE_RIGHT;
      end
      ctl.start = accept;
      ctl.drain = (state == S_DRAIN);
      ctl.sel   = (do_rem || do_read) && (IX == ep);
      ctl.chk   = do_chk && (IX < cnt_x);
    end

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid
      assign left_d = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d  = '0;
      assign pick_in  = '0;
      assign found_in = 1'b0;
    end else begin : g_body
      assign right_d  = data[i+1];
      assign pick_in  = pick[i+1];
      assign found_in = found_c[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .value      (req.value),
      .left_data  (left_d),
      .right_data (right_d),
      .pick_in    (pick_in),
      .found_in   (found_in),
      .data       (data[i]),
      .pick       (pick[i]),
      .found      (found_c[i])
    );
  end

  `PLE_ASSERT(a_count_bound, count <= CW'(DEPTH))
  `PLE_ASSERT_MSG(a_ins_grows, (accept && do_ins) |=> (count == $past(count) + CW'(1)), "insert lost")
  `PLE_ASSERT(a_drain_blocks, (accept && need_drain) |=> !req.ready)
  `PLE_ASSERT(a_drain_done, (state == S_DRAIN && out_load) |-> (cnt == KW'(DEPTH - 1)))

endmodule

// ----- verif/ple_checker.sv -----
// result checker for the positional list engine: watches both channels,
// predicts each response from the accepted requests and compares them
// depends on ple_pkg and ple_if
module ple_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  ple_req_if   req,
  ple_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   level,
  output int   full_hits,
  output int   empty_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ple_pkg::status_t                  status;
    logic signed [ple_pkg::DATA_W-1:0] value_out;
    logic                              found;
    logic [ple_pkg::CNT_W-1:0]         count_out;
  } list_rsp_t;

  logic signed [ple_pkg::DATA_W-1:0] list_vals [DEPTH];
  int                                list_len;
  list_rsp_t                         pending_rsps [$];

  // removes one entry and closes the gap toward the head
  function automatic logic signed [ple_pkg::DATA_W-1:0] pull_entry(int p);
    logic signed [ple_pkg::DATA_W-1:0] v;
    int i;
    v = list_vals[p];
    for (i = p; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
    list_len--;
    return v;
  endfunction

  function automatic list_rsp_t apply_request(ple_pkg::action_t act,
                                              logic signed [ple_pkg::DATA_W-1:0] val,
                                              logic [ple_pkg::POS_W-1:0] pos);
    list_rsp_t r;
    int p;
    int i;
    r.status    = ple_pkg::ST_OK;
    r.value_out = '0;
    r.found     = 1'b0;
    case (act)
      ple_pkg::ACT_INS_HEAD, ple_pkg::ACT_INS_TAIL, ple_pkg::ACT_INS_AT: begin
        if (act == ple_pkg::ACT_INS_HEAD) p = 0;
        else if (act == ple_pkg::ACT_INS_TAIL) p = list_len;
        else p = int'(pos);
        if (p > list_len) begin
          r.status = ple_pkg::ST_BADPOS;
        end else if (list_len >= DEPTH) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = val;
          list_len++;
        end
      end
      ple_pkg::ACT_REM_HEAD, ple_pkg::ACT_REM_TAIL: begin
        if (list_len == 0) r.status = ple_pkg::ST_EMPTY;
        else r.value_out = pull_entry(act == ple_pkg::ACT_REM_HEAD ? 0 : list_len - 1);
      end
      ple_pkg::ACT_REM_AT: begin
        if (int'(pos) >= list_len) r.status = ple_pkg::ST_BADPOS;
        else r.value_out = pull_entry(int'(pos));
      end
      ple_pkg::ACT_READ_AT: begin
        if (int'(pos) >= list_len) r.status = ple_pkg::ST_BADPOS;
        else r.value_out = list_vals[pos];
      end
      default: begin
        for (i = 0; i < list_len; i++) begin
          if (list_vals[i] == val) r.found = 1'b1;
        end
      end
    endcase
    r.count_out = list_len[ple_pkg::CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (rst) begin
      list_len = 0;
      pending_rsps.delete();
      mismatches  <= 0;
      outstanding <= 0;
      checked     <= 0;
      level       <= 0;
      full_hits   <= 0;
      empty_hits  <= 0;
    end else begin
      // a response at this edge always belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        got.status    = rsp.status;
        got.value_out = rsp.value_out;
        got.found     = rsp.found;
        got.count_out = rsp.count_out;
        if (pending_rsps.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response: status %0d value %0d found %b count %0d",
                     got.status, got.value_out, got.found, got.count_out);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_rsps.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch on response %0d: expected status %0d value %0d found %b count %0d",
                       checked, want.status, want.value_out, want.found, want.count_out);
              $display("  got status %0d value %0d found %b count %0d",
                       got.status, got.value_out, got.found, got.count_out);
            end
            mismatches <= mismatches + 1;
          end
          checked <= checked + 1;
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(req.action, req.value, req.position);
        pending_rsps.push_back(want);
        if (want.status == ple_pkg::ST_FULL) full_hits <= full_hits + 1;
        if (want.status == ple_pkg::ST_EMPTY) empty_hits <= empty_hits + 1;
      end
      outstanding <= pending_rsps.size();
      level       <= list_len;
    end
  end

endmodule

// ----- verif/tb.sv -----
// testbench top of the positional list engine: clock, reset, request
// stimulus, response back-pressure and the verdict
// depends on ple_pkg, ple_if, positional_list_engine_core and ple_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int N_RANDOM   = 1125;
  localparam int N_QUIET    = 150;

  logic clk = 1'b0;
  logic rst;

  ple_req_if req_ch();
  ple_rsp_if rsp_ch();

  int mismatches;
  int outstanding;
  int checked;
  int level;
  int full_hits;
  int empty_hits;

  int gap_pct;
  bit quiet;
  int stall_left;
  int sent;
  logic signed [ple_pkg::DATA_W-1:0] recent_vals [8];

  positional_list_engine_core #(.DEPTH(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ple_checker #(.DEPTH(DEPTH)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .level       (level),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // response side back-pressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 9) - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input ple_pkg::action_t act,
                           input logic signed [ple_pkg::DATA_W-1:0] val,
                           input logic [ple_pkg::POS_W-1:0] pos);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.value    <= val;
    req_ch.position <= pos;
    if (act == ple_pkg::ACT_INS_HEAD || act == ple_pkg::ACT_INS_TAIL ||
        act == ple_pkg::ACT_INS_AT)
      recent_vals[$urandom_range(0, 7)] = val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [ple_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 75) return recent_vals[$urandom_range(0, 7)];
    if (r < 85) return $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic [ple_pkg::POS_W-1:0] pick_position(int lvl);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ple_pkg::POS_W'($urandom_range(0, lvl));
    if (r < 90) return ple_pkg::POS_W'(lvl + 1);
    return ple_pkg::POS_W'($urandom_range(0, 31));
  endfunction

  initial begin
    int i;
    int r;
    bit filling;
    ple_pkg::action_t act;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ple_pkg::ACT_INS_HEAD;
    req_ch.value    <= '0;
    req_ch.position <= '0;
    rst             <= 1'b1;
    gap_pct = 0;
    quiet   = 1'b0;
    sent    = 0;
    filling = 1'b1;
    for (i = 0; i < 8; i++) recent_vals[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corner cases
    gap_pct = 20;
    send_item(ple_pkg::ACT_REM_HEAD, 32'sd5, 5'd0);
    send_item(ple_pkg::ACT_REM_TAIL, 32'sd5, 5'd0);
    send_item(ple_pkg::ACT_REM_AT, 32'sd5, 5'd0);
    send_item(ple_pkg::ACT_READ_AT, 32'sd5, 5'd16);
    send_item(ple_pkg::ACT_CONTAINS, 32'sd0, 5'd0);
    send_item(ple_pkg::ACT_INS_AT, 32'sd9, 5'd1);
    // insert at zero behaves as a head insert
    send_item(ple_pkg::ACT_INS_AT, 32'sh7fffffff, 5'd0);
    send_item(ple_pkg::ACT_INS_HEAD, 32'sh80000000, 5'd31);
    send_item(ple_pkg::ACT_INS_TAIL, -32'sd1, 5'd0);
    send_item(ple_pkg::ACT_INS_AT, 32'sd0, 5'd3);
    send_item(ple_pkg::ACT_INS_AT, 32'sh12345678, 5'd2);
    send_item(ple_pkg::ACT_READ_AT, 32'sd0, 5'd4);
    send_item(ple_pkg::ACT_CONTAINS, 32'sh80000000, 5'd0);
    send_item(ple_pkg::ACT_CONTAINS, 32'sh5555aaaa, 5'd0);
    send_item(ple_pkg::ACT_REM_AT, 32'sd0, 5'd2);
    send_item(ple_pkg::ACT_REM_TAIL, 32'sd0, 5'd0);
    send_item(ple_pkg::ACT_REM_HEAD, 32'sd0, 5'd0);
    // fill to the top, then push past it
    for (i = 2; i < DEPTH; i++) send_item(ple_pkg::ACT_INS_TAIL, $urandom, 5'd0);
    send_item(ple_pkg::ACT_INS_TAIL, 32'sd1, 5'd0);
    send_item(ple_pkg::ACT_INS_AT, 32'sd1, 5'd17);
    send_item(ple_pkg::ACT_INS_AT, 32'sd1, 5'd16);
    send_item(ple_pkg::ACT_READ_AT, 32'sd0, 5'd15);
    send_item(ple_pkg::ACT_READ_AT, 32'sd0, 5'd16);
    send_item(ple_pkg::ACT_REM_AT, 32'sd0, 5'd31);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0 && !quiet) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 15;
          default: gap_pct = 35;
        endcase
      end
      if (i == N_RANDOM - N_QUIET) begin
        gap_pct = 0;
        quiet   = 1'b1;
      end
      if (i == N_RANDOM / 2) begin
        req_ch.valid <= 1'b0;
        // let the last accepted item reach the outstanding count first
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      // swing between filling and draining so both ends are reached often
      if (level >= DEPTH) filling = 1'b0;
      else if (level == 0) filling = 1'b1;
      else if ($urandom_range(0, 39) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < (filling ? 55 : 20)) begin
        case ($urandom_range(0, 2))
          0: act = ple_pkg::ACT_INS_HEAD;
          1: act = ple_pkg::ACT_INS_TAIL;
          default: act = ple_pkg::ACT_INS_AT;
        endcase
      end else if (r < 75) begin
        case ($urandom_range(0, 2))
          0: act = ple_pkg::ACT_REM_HEAD;
          1: act = ple_pkg::ACT_REM_TAIL;
          default: act = ple_pkg::ACT_REM_AT;
        endcase
      end else if (r < 88) begin
        act = ple_pkg::ACT_READ_AT;
      end else begin
        act = ple_pkg::ACT_CONTAINS;
      end
      send_item(act, pick_value(), pick_position(level));
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    $display("%0d requests sent, %0d responses checked against the predicted list",
             sent, checked);
    $display("full list rejections: %0d, empty list rejections: %0d", full_hits, empty_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d responses outstanding", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_if.sv
rtl/ple_cell.sv
rtl/positional_list_engine_core.sv
verif/ple_checker.sv
verif/tb.sv
